FILE: hdl/bbia_pkg.sv
// Shared constants for the bitmap zone and inode allocator.
`default_nettype none
package bbia_pkg;

  // Parameter defaults
  localparam int MAP_BLOCK_BITS_DEF   = 8192;
  localparam int ZONE_MAP_BLOCKS_DEF  = 8;
  localparam int INODE_MAP_BLOCKS_DEF = 8;

  // Bitmap word geometry
  localparam int WORD_BITS  = 64;
  localparam int WORD_SHIFT = 6;

  // Field widths
  localparam int NUM_W    = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  // Inode numbering starts at one
  localparam logic [NUM_W-1:0] INODE_BASE = 16'd1;

  // Request codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;
  localparam logic POOL_ZONE  = 1'b0;
  localparam logic POOL_INODE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BADFREE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DATA_ZONE_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INODE_LIMIT     = 2'd2;

endpackage
`default_nettype wire

FILE: hdl/bbia_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bbia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/bitmap_block_inode_allocator_core.sv
// First-fit zone and inode bitmap allocator with a two-level full-word summary.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+----------------------------------
//  s_*     | in        | s_tvalid / s_tready     | tdata: number; tuser: func, pool
//  m_*     | out       | m_tvalid / m_tready     | tdata: number_res; tuser: status
//  cfg_*   | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data (16 bits)
//
// Steps: an allocate runs from accept to result valid through top-level search,
// summary word read, bitmap word read, limit check and write-back, and output
// load; a free runs through range check, read and write-back, and output load.
// A request that fails early skips the remaining steps. The registered reads of
// the bitmap and summary memories set these steps, one item at a time; the
// next word is taken in the cycle after the result is loaded.
// Reset: the block sweeps both memories to zero, one word per cycle, and holds
// s_tready low meanwhile; configuration writes are taken throughout.
// Stalls: s_tready stays low while an item is in work. A finished result waits
// in the output register; the next item is accepted meanwhile and only its own
// result waits for m_tready.
`default_nettype none
module bitmap_block_inode_allocator_core #(
  parameter int MAP_BLOCK_BITS   = bbia_pkg::MAP_BLOCK_BITS_DEF,
  parameter int ZONE_MAP_BLOCKS  = bbia_pkg::ZONE_MAP_BLOCKS_DEF,
  parameter int INODE_MAP_BLOCKS = bbia_pkg::INODE_MAP_BLOCKS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [bbia_pkg::NUM_W-1:0]        s_tdata,   // [15:0] number
  input  wire logic [1:0]                        s_tuser,   // [0] func, [1] pool
  // result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [bbia_pkg::NUM_W-1:0]        m_tdata,   // [15:0] number_res
  output logic      [bbia_pkg::STATUS_W-1:0]     m_tuser,   // [1:0] status
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bbia_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bbia_pkg::NUM_W-1:0]        cfg_data
);

  // Geometry: bitmap words per pool, summary words (one bit per bitmap word)
  localparam int WB          = bbia_pkg::WORD_BITS;
  localparam int WS          = bbia_pkg::WORD_SHIFT;
  localparam int NW16        = bbia_pkg::NUM_W;
  localparam int ZONE_BITS   = ZONE_MAP_BLOCKS * MAP_BLOCK_BITS;
  localparam int INODE_BITS  = INODE_MAP_BLOCKS * MAP_BLOCK_BITS;
  localparam int ZONE_WORDS  = (ZONE_BITS + WB - 1) / WB;
  localparam int INODE_WORDS = (INODE_BITS + WB - 1) / WB;
  localparam int ZONE_SUMS   = (ZONE_WORDS + WB - 1) / WB;
  localparam int INODE_SUMS  = (INODE_WORDS + WB - 1) / WB;
  localparam int MS          = (ZONE_SUMS > INODE_SUMS) ? ZONE_SUMS : INODE_SUMS;
  localparam int SW          = (MS > 1) ? $clog2(MS) : 1;
  localparam int WW          = SW + WS;            // bitmap word index
  localparam int IDXW        = WW + WS;            // bit index
  localparam int NW          = ((IDXW > NW16) ? IDXW : NW16) + 1;
  localparam int MAP_DEPTH   = ZONE_WORDS + INODE_WORDS;
  localparam int SUM_DEPTH   = ZONE_SUMS + INODE_SUMS;
  localparam int MAW         = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int SAW         = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
  localparam int CW          = $clog2(MAP_DEPTH + 1);

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_A_TOP = 4'd2;
  localparam logic [3:0] ST_A_SUM = 4'd3;
  localparam logic [3:0] ST_A_MAP = 4'd4;
  localparam logic [3:0] ST_A_CHK = 4'd5;
  localparam logic [3:0] ST_F_CHK = 4'd6;
  localparam logic [3:0] ST_F_RD  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  // Lowest clear bit of a word: {found, index}
  function automatic logic [WS:0] low_clear(input logic [WB-1:0] v);
    logic [WS:0] r;
    r = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (!v[i]) r = {1'b1, WS'(i)};
    end
    return r;
  endfunction

  logic [3:0]       state;
  logic [CW-1:0]    clr_cnt;

  // configuration
  logic [NW16-1:0]  data_zone_start;
  logic [NW16-1:0]  zone_limit;
  logic [NW16-1:0]  inode_limit;

  // captured request
  logic             pool_q;
  logic [NW16-1:0]  number_q;

  // working registers of the sequencer
  logic [SW-1:0]    s_q;         // summary word index
  logic [WS-1:0]    b_q;         // bit within summary word
  logic [WS-1:0]    c_q;         // bit within bitmap word
  logic [WW-1:0]    w_q;         // bitmap word index
  logic [MAW-1:0]   map_addr_q;
  logic [SAW-1:0]   sum_addr_q;
  logic [WB-1:0]    mapword_q;
  logic [WB-1:0]    sumword_q;
  logic [NW16-1:0]  res_num;
  logic [bbia_pkg::STATUS_W-1:0] res_st;

  // full-summary-word flags, one per summary word and pool
  logic [MS-1:0]    top_z;
  logic [MS-1:0]    top_i;

  // memory ports
  logic             map_we;
  logic [MAW-1:0]   map_waddr;
  logic [WB-1:0]    map_wdata;
  logic [MAW-1:0]   map_raddr;
  logic [WB-1:0]    map_rdata;
  logic             sum_we;
  logic [SAW-1:0]   sum_waddr;
  logic [WB-1:0]    sum_wdata;
  logic [SAW-1:0]   sum_raddr;
  logic [WB-1:0]    sum_rdata;

  // pool-dependent views
  logic [NW16-1:0]  zbase;
  logic [NW16-1:0]  base_cur;
  logic [NW16-1:0]  limit_cur;
  logic [NW-1:0]    bits_cur;
  logic [NW-1:0]    words_cur;
  logic [MS-1:0]    top_cur;
  logic [MAW-1:0]   map_off;
  logic [SAW-1:0]   sum_off;

  // search and check results
  logic             top_hit;
  logic [SW-1:0]    top_s;
  logic [WS:0]      sum_enc;
  logic [WS:0]      map_enc;
  logic [WW-1:0]    w_cand;
  logic             w_bad;
  logic [NW-1:0]    fr_diff;
  logic             fr_bad;
  logic             fr_ok;
  logic [NW-1:0]    idx_a;
  logic [NW-1:0]    n_a;
  logic             alloc_ok;
  logic [WB-1:0]    map_set;
  logic [WB-1:0]    sum_set;
  logic             map_full;
  logic             sum_full;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Zone base saturates at zero when the first data zone is zero
  assign zbase     = (data_zone_start == '0) ? '0 : data_zone_start - NW16'(1);
  assign base_cur  = (pool_q == bbia_pkg::POOL_INODE) ? bbia_pkg::INODE_BASE : zbase;
  assign limit_cur = (pool_q == bbia_pkg::POOL_INODE) ? inode_limit : zone_limit;
  assign bits_cur  = (pool_q == bbia_pkg::POOL_INODE) ? NW'(INODE_BITS) : NW'(ZONE_BITS);
  assign words_cur = (pool_q == bbia_pkg::POOL_INODE) ? NW'(INODE_WORDS) : NW'(ZONE_WORDS);
  assign top_cur   = (pool_q == bbia_pkg::POOL_INODE) ? top_i : top_z;
  assign map_off   = (pool_q == bbia_pkg::POOL_INODE) ? MAW'(ZONE_WORDS) : '0;
  assign sum_off   = (pool_q == bbia_pkg::POOL_INODE) ? SAW'(ZONE_SUMS) : '0;

  // Lowest summary word of the pool that still has a non-full bitmap word
  always_comb begin
    top_hit = 1'b0;
    top_s   = '0;
    for (int i = MS - 1; i >= 0; i--) begin
      if (((pool_q == bbia_pkg::POOL_INODE) ? (i < INODE_SUMS) : (i < ZONE_SUMS)) &&
          !top_cur[i]) begin
        top_hit = 1'b1;
        top_s   = SW'(i);
      end
    end
  end

  assign sum_enc = low_clear(sum_rdata);
  assign map_enc = low_clear(map_rdata);
  assign w_cand  = {s_q, sum_enc[WS-1:0]};
  // a word past the pool's end means every real bit is taken
  assign w_bad   = !sum_enc[WS] || (NW'(w_cand) >= words_cur);

  // Free: number to bit index and range check
  assign fr_diff = NW'(number_q) - NW'(base_cur);
  assign fr_bad  = (number_q < base_cur) || (fr_diff >= bits_cur);
  assign fr_ok   = map_rdata[c_q];

  // Allocate: number and limit check
  assign idx_a    = NW'({w_q, c_q});
  assign n_a      = NW'(base_cur) + idx_a;
  assign alloc_ok = (idx_a < bits_cur) && (n_a < NW'(limit_cur));
  assign map_set  = mapword_q | (WB'(1) << c_q);
  assign sum_set  = sumword_q | (WB'(1) << b_q);
  assign map_full = &map_set;
  assign sum_full = &sum_set;

  // Read addresses
  always_comb begin
    if (state == ST_F_CHK) begin
      map_raddr = map_off + MAW'(fr_diff[IDXW-1:WS]);
      sum_raddr = sum_off + SAW'(fr_diff[IDXW-1:2*WS]);
    end else begin
      map_raddr = map_off + MAW'(w_cand);
      sum_raddr = sum_off + SAW'(top_s);
    end
  end

  // Write ports: clearing sweep, allocate mark, free clear
  always_comb begin
    map_we    = 1'b0;
    map_waddr = map_addr_q;
    map_wdata = map_set;
    sum_we    = 1'b0;
    sum_waddr = sum_addr_q;
    sum_wdata = sum_set;
    unique case (state)
      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_cnt[MAW-1:0];
        map_wdata = '0;
        sum_we    = (clr_cnt < CW'(SUM_DEPTH));
        sum_waddr = clr_cnt[SAW-1:0];
        sum_wdata = '0;
      end
      ST_A_CHK: begin
        map_we = alloc_ok;
        sum_we = alloc_ok && map_full;
      end
      ST_F_RD: begin
        map_we    = fr_ok;
        map_wdata = map_rdata & ~(WB'(1) << c_q);
        sum_we    = fr_ok;
        sum_wdata = sum_rdata & ~(WB'(1) << b_q);
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      data_zone_start <= NW16'(1);
      zone_limit      <= '0;
      inode_limit     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bbia_pkg::REG_DATA_ZONE_START: data_zone_start <= cfg_data;
        bbia_pkg::REG_ZONE_LIMIT:      zone_limit      <= cfg_data;
        bbia_pkg::REG_INODE_LIMIT:     inode_limit     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
      top_z    <= '0;
      top_i    <= '0;
    end else begin
      // drop a taken result; ST_OUT decides the valid flag on its own
      if (m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + CW'(1);
          if (clr_cnt == CW'(MAP_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            pool_q   <= s_tuser[1];
            number_q <= s_tdata;
            state    <= (s_tuser[0] == bbia_pkg::FUNC_FREE) ? ST_F_CHK : ST_A_TOP;
          end
        end
        ST_A_TOP: begin
          s_q        <= top_s;
          sum_addr_q <= sum_raddr;
          if (top_hit) begin
            state <= ST_A_SUM;
          end else begin
            res_num <= '0;
            res_st  <= bbia_pkg::STATUS_FULL;
            state   <= ST_OUT;
          end
        end
        ST_A_SUM: begin
          sumword_q  <= sum_rdata;
          b_q        <= sum_enc[WS-1:0];
          w_q        <= w_cand;
          map_addr_q <= map_raddr;
          if (w_bad) begin
            res_num <= '0;
            res_st  <= bbia_pkg::STATUS_FULL;
            state   <= ST_OUT;
          end else begin
            state <= ST_A_MAP;
          end
        end
        ST_A_MAP: begin
          mapword_q <= map_rdata;
          c_q       <= map_enc[WS-1:0];
          if (map_enc[WS]) begin
            state <= ST_A_CHK;
          end else begin
            res_num <= '0;
            res_st  <= bbia_pkg::STATUS_FULL;
            state   <= ST_OUT;
          end
        end
        ST_A_CHK: begin
          if (alloc_ok) begin
            res_num <= n_a[NW16-1:0];
            res_st  <= bbia_pkg::STATUS_OK;
            // mark the summary word full once its last bitmap word fills
            if (map_full && sum_full) begin
              if (pool_q == bbia_pkg::POOL_INODE) top_i[s_q] <= 1'b1;
              else top_z[s_q] <= 1'b1;
            end
          end else begin
            res_num <= '0;
            res_st  <= bbia_pkg::STATUS_FULL;
          end
          state <= ST_OUT;
        end
        ST_F_CHK: begin
          c_q        <= fr_diff[WS-1:0];
          b_q        <= fr_diff[2*WS-1:WS];
          s_q        <= fr_diff[IDXW-1:2*WS];
          map_addr_q <= map_raddr;
          sum_addr_q <= sum_raddr;
          res_num    <= '0;
          if (fr_bad) begin
            res_st <= bbia_pkg::STATUS_BADFREE;
            state  <= ST_OUT;
          end else begin
            state <= ST_F_RD;
          end
        end
        ST_F_RD: begin
          if (fr_ok) begin
            res_st <= bbia_pkg::STATUS_OK;
            if (pool_q == bbia_pkg::POOL_INODE) top_i[s_q] <= 1'b0;
            else top_z[s_q] <= 1'b0;
          end else begin
            res_st <= bbia_pkg::STATUS_BADFREE;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          // hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_num;
            m_tuser  <= res_st;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Bitmap words of both pools; inode words follow the zone words
  bbia_ram #(
    .WIDTH (WB),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Summary words: bit set when the matching bitmap word is full
  bbia_ram #(
    .WIDTH (WB),
    .DEPTH (SUM_DEPTH)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

endmodule
`default_nettype wire

FILE: tb/bitmap_block_inode_allocator_core_test.sv
// Self-checking testbench for the zone and inode bitmap allocator core.
`default_nettype none
module bitmap_block_inode_allocator_core_test;

  // Field and word widths
  localparam int NUM_W      = bbia_pkg::NUM_W;
  localparam int STATUS_W   = bbia_pkg::STATUS_W;
  localparam int CFG_IDX_W  = bbia_pkg::CFG_IDX_W;
  localparam int WORD_BITS  = bbia_pkg::WORD_BITS;
  localparam int WORD_SHIFT = bbia_pkg::WORD_SHIFT;

  // Pool geometry at the default size, one row of words per pool
  localparam int POOL_BITS  = bbia_pkg::MAP_BLOCK_BITS_DEF * bbia_pkg::ZONE_MAP_BLOCKS_DEF;
  localparam int POOL_WORDS = POOL_BITS / WORD_BITS;

  // Index past the last register; writes to it must leave every register alone
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 190;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_TRIGGER = 250;

  typedef struct packed {
    logic [NUM_W-1:0]    number_res;
    logic [STATUS_W-1:0] status;
  } alloc_outcome_t;

  typedef enum logic { ROW_REQ, ROW_REG } row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic                 func;
    logic                 pool;
    logic [NUM_W-1:0]     value;
    logic [CFG_IDX_W-1:0] reg_sel;
    bit                   typed;
    alloc_outcome_t       want;
  } plan_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [NUM_W-1:0]     s_tdata = '0;    // [15:0] number
  logic [1:0]           s_tuser = '0;    // [0] func, [1] pool
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [NUM_W-1:0]     m_tdata;         // [15:0] number_res
  logic [STATUS_W-1:0]  m_tuser;         // [1:0] status
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [NUM_W-1:0]     cfg_data = '0;

  // Shadow of the block: both bitmaps and the three registers
  bit [WORD_BITS-1:0] occupancy [2][POOL_WORDS];
  int unsigned        span_top [2];      // one past the highest bit ever granted
  int unsigned        zone_start_m  = 1;
  int unsigned        zone_limit_m  = 0;
  int unsigned        inode_limit_m = 0;

  alloc_outcome_t outcome_q[$];
  plan_row_t      plan[$];

  int errors, results_seen, reg_writes;
  int granted, refused, freed, rejected;
  int tx_idle_pct, rx_idle_pct;
  bit tail_quiet, long_hold_done;

  bitmap_block_inode_allocator_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run (reset sweep included)
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Zone numbering starts at data_zone_start - 1, held at zero for a zero start
  function automatic int unsigned pool_base(logic pool);
    if (pool == bbia_pkg::POOL_INODE) return 32'(bbia_pkg::INODE_BASE);
    return (zone_start_m == 0) ? 0 : zone_start_m - 1;
  endfunction

  function automatic int unsigned pool_limit(logic pool);
    return (pool == bbia_pkg::POOL_INODE) ? inode_limit_m : zone_limit_m;
  endfunction

  // Work out the result of one request and move the shadow bitmaps along
  function automatic alloc_outcome_t apply_request(logic func, logic pool,
                                                   logic [NUM_W-1:0] num);
    alloc_outcome_t res;
    int unsigned    base, idx, w, b;
    bit             found;
    base = pool_base(pool);
    res.number_res = '0;
    found = 1'b0;
    idx = 0;
    if (func == bbia_pkg::FUNC_ALLOC) begin
      // First fit: lowest clear bit, then refuse it if its number reaches the limit
      for (w = 0; w < POOL_WORDS && !found; w++)
        if (occupancy[pool][w] != '1)
          for (b = 0; b < WORD_BITS && !found; b++)
            if (!occupancy[pool][w][b]) begin
              idx = w * WORD_BITS + b;
              found = 1'b1;
            end
      if (found && base + idx < pool_limit(pool)) begin
        occupancy[pool][idx >> WORD_SHIFT][idx % WORD_BITS] = 1'b1;
        if (idx + 1 > span_top[pool]) span_top[pool] = idx + 1;
        res.number_res = NUM_W'(base + idx);
        res.status = bbia_pkg::STATUS_OK;
        granted++;
      end else begin
        res.status = bbia_pkg::STATUS_FULL;
        refused++;
      end
    end else begin
      // Free checks only the bitmap range and the bit, never the current limit
      if (32'(num) >= base) begin
        idx = 32'(num) - base;
        if (idx < POOL_BITS) found = occupancy[pool][idx >> WORD_SHIFT][idx % WORD_BITS];
      end
      if (found) begin
        occupancy[pool][idx >> WORD_SHIFT][idx % WORD_BITS] = 1'b0;
        res.status = bbia_pkg::STATUS_OK;
        freed++;
      end else begin
        res.status = bbia_pkg::STATUS_BADFREE;
        rejected++;
      end
    end
    return res;
  endfunction

  function automatic plan_row_t req(logic func, logic pool, logic [NUM_W-1:0] num);
    plan_row_t r;
    r.kind = ROW_REQ;
    r.func = func;
    r.pool = pool;
    r.value = num;
    r.reg_sel = REG_UNUSED;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t chk(logic func, logic pool, logic [NUM_W-1:0] num,
                                    logic [NUM_W-1:0] exp_num,
                                    logic [STATUS_W-1:0] exp_status);
    plan_row_t r;
    r = req(func, pool, num);
    r.typed = 1'b1;
    r.want.number_res = exp_num;
    r.want.status = exp_status;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] sel, logic [NUM_W-1:0] val);
    plan_row_t r;
    r = req(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_ZONE, val);
    r.kind = ROW_REG;
    r.reg_sel = sel;
    return r;
  endfunction

  // Offer one request word, hold it until taken, then log what it must produce.
  // Enter and leave at a falling edge.
  task automatic send_request(logic func, logic pool, logic [NUM_W-1:0] num,
                              bit typed, alloc_outcome_t want);
    alloc_outcome_t predicted;
    if (!tail_quiet && tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= num;
    s_tuser  <= {pool, func};
    do @(posedge clk); while (!s_tready);
    predicted = apply_request(func, pool, num);
    outcome_q.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Drain the block, then write one register. Enter and leave at a falling edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [NUM_W-1:0] val);
    s_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (sel)
      bbia_pkg::REG_DATA_ZONE_START: zone_start_m  = 32'(val);
      bbia_pkg::REG_ZONE_LIMIT:      zone_limit_m  = 32'(val);
      bbia_pkg::REG_INODE_LIMIT:     inode_limit_m = 32'(val);
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Compare each result word with the oldest outstanding prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result number_res %0d status %0d", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        alloc_outcome_t exp_out;
        exp_out = outcome_q.pop_front();
        if (m_tdata !== exp_out.number_res) begin
          $display("%0t: number_res expected %0d, got %0d", $time, exp_out.number_res,
                   m_tdata);
          errors++;
        end
        if (m_tuser !== exp_out.status) begin
          $display("%0t: status expected %0d, got %0d", $time, exp_out.status, m_tuser);
          errors++;
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off that backs the block up
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= HOLD_TRIGGER) begin
        m_tready <= 1'b0;
        long_hold_done = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!tail_quiet && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int               p, k, r;
    int               dzs, zl, il;
    logic             func, pool;
    logic [NUM_W-1:0] num;
    int unsigned      idx;
    // After reset: limits of zero refuse every allocation, nothing is held
    plan.push_back(chk(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_ZONE, 16'd0, 16'd0,
                       bbia_pkg::STATUS_FULL));
    plan.push_back(chk(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_INODE, 16'd0, 16'd0,
                       bbia_pkg::STATUS_FULL));
    plan.push_back(chk(bbia_pkg::FUNC_FREE, bbia_pkg::POOL_ZONE, 16'd0, 16'd0,
                       bbia_pkg::STATUS_BADFREE));
    plan.push_back(chk(bbia_pkg::FUNC_FREE, bbia_pkg::POOL_INODE, 16'd0, 16'd0,
                       bbia_pkg::STATUS_BADFREE));
    // Unknown register index must not touch the zone limit
    plan.push_back(reg_row(REG_UNUSED, 16'hFFFF));
    plan.push_back(chk(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_ZONE, 16'd0, 16'd0,
                       bbia_pkg::STATUS_FULL));
    // Widest limits with a zero zone start: base saturates at zero
    plan.push_back(reg_row(bbia_pkg::REG_ZONE_LIMIT, 16'hFFFF));
    plan.push_back(reg_row(bbia_pkg::REG_INODE_LIMIT, 16'hFFFF));
    plan.push_back(reg_row(bbia_pkg::REG_DATA_ZONE_START, 16'd0));
    plan.push_back(req(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_ZONE,  16'hFFFF));
    plan.push_back(req(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_ZONE,  16'd0));
    plan.push_back(req(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_INODE, 16'd0));
    plan.push_back(req(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_INODE, 16'd0));
    plan.push_back(chk(bbia_pkg::FUNC_FREE, bbia_pkg::POOL_INODE, 16'hFFFF, 16'd0,
                       bbia_pkg::STATUS_BADFREE));
    plan.push_back(req(bbia_pkg::FUNC_FREE, bbia_pkg::POOL_INODE, 16'd1));
    plan.push_back(chk(bbia_pkg::FUNC_FREE, bbia_pkg::POOL_INODE, 16'd1, 16'd0,
                       bbia_pkg::STATUS_BADFREE));
    plan.push_back(req(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_INODE, 16'd0));
    // Highest zone start: next free zone lands at or past the limit
    plan.push_back(reg_row(bbia_pkg::REG_DATA_ZONE_START, 16'hFFFF));
    plan.push_back(chk(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_ZONE, 16'd0, 16'd0,
                       bbia_pkg::STATUS_FULL));
    plan.push_back(req(bbia_pkg::FUNC_FREE, bbia_pkg::POOL_ZONE, 16'hFFFE));
    plan.push_back(chk(bbia_pkg::FUNC_FREE, bbia_pkg::POOL_ZONE, 16'd100, 16'd0,
                       bbia_pkg::STATUS_BADFREE));
    plan.push_back(req(bbia_pkg::FUNC_FREE, bbia_pkg::POOL_ZONE, 16'hFFFF));
    plan.push_back(req(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_ZONE, 16'd0));
    plan.push_back(chk(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_ZONE, 16'd0, 16'd0,
                       bbia_pkg::STATUS_FULL));
    // Shrink limits until no new allocation fits; frees still go through
    plan.push_back(reg_row(bbia_pkg::REG_INODE_LIMIT, 16'd3));
    plan.push_back(reg_row(bbia_pkg::REG_ZONE_LIMIT, 16'd0));
    plan.push_back(chk(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_INODE, 16'd0, 16'd0,
                       bbia_pkg::STATUS_FULL));
    plan.push_back(chk(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_ZONE, 16'd0, 16'd0,
                       bbia_pkg::STATUS_FULL));
    plan.push_back(req(bbia_pkg::FUNC_FREE, bbia_pkg::POOL_ZONE, 16'hFFFE));
    plan.push_back(chk(bbia_pkg::FUNC_FREE, bbia_pkg::POOL_ZONE, 16'd0, 16'd0,
                       bbia_pkg::STATUS_BADFREE));
    plan.push_back(req(bbia_pkg::FUNC_FREE, bbia_pkg::POOL_INODE, 16'd2));
    plan.push_back(req(bbia_pkg::FUNC_ALLOC, bbia_pkg::POOL_INODE, 16'd0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed plan with no idling on either side
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].reg_sel, plan[i].value);
      else send_request(plan[i].func, plan[i].pool, plan[i].value, plan[i].typed,
                        plan[i].want);
    end

    // Random phases, each under its own register setting
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin dzs = 1; zl = 65535; il = 65535; end
        1: begin dzs = 0; zl = $urandom_range(1, 150); il = $urandom_range(1, 150); end
        2: begin dzs = 65535; zl = 65535; il = 0; end
        3: begin dzs = $urandom_range(0, 65535); zl = $urandom_range(0, 65535);
                 il = $urandom_range(0, 65535); end
        4: begin dzs = $urandom_range(1, 300); zl = dzs + $urandom_range(0, 400);
                 il = 65535; end
        default: begin
          dzs = $urandom_range(0, 600);
          zl  = $urandom_range(0, 1) ? 65535 : dzs + $urandom_range(0, 300);
          il  = $urandom_range(0, 400);
        end
      endcase
      if (zl > 65535) zl = 65535;
      write_reg(bbia_pkg::REG_DATA_ZONE_START, dzs[15:0]);
      write_reg(bbia_pkg::REG_ZONE_LIMIT, zl[15:0]);
      write_reg(bbia_pkg::REG_INODE_LIMIT, il[15:0]);
      if (p == 1 || p == 3) write_reg(REG_UNUSED, NUM_W'($urandom_range(0, 65535)));

      // Quiet first and last phases; the rest pick their own idling rates
      tail_quiet = (p == PHASES - 1);
      case ($urandom_range(0, 2))
        0: tx_idle_pct = 0;
        1: tx_idle_pct = 8;
        default: tx_idle_pct = 30;
      endcase
      case ($urandom_range(0, 2))
        0: rx_idle_pct = 0;
        1: rx_idle_pct = 8;
        default: rx_idle_pct = 30;
      endcase
      if (p == 0) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        pool = 1'($urandom_range(0, 1));
        num = NUM_W'($urandom_range(0, 65535));
        func = (r < 45) ? bbia_pkg::FUNC_ALLOC : bbia_pkg::FUNC_FREE;
        if (r >= 45 && r < 85 && span_top[pool] != 0) begin
          // Mostly aim at a held bit so the maps keep churning
          for (int t = 0; t < 4; t++) begin
            idx = $urandom_range(0, span_top[pool] - 1);
            num = NUM_W'(pool_base(pool) + idx);
            if (occupancy[pool][idx >> WORD_SHIFT][idx % WORD_BITS]) break;
          end
        end else if (r >= 93) begin
          // Near the bottom of the pool: double frees and below-base numbers
          num = NUM_W'(pool_base(pool) + $urandom_range(0, 63) - $urandom_range(0, 2));
        end
        send_request(func, pool, num, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Ran %0d requests over %0d register writes: %0d grants, %0d refusals,",
             granted + refused + freed + rejected, reg_writes, granted, refused);
    $display("%0d frees, %0d rejected frees, one %0d-cycle result hold-off.",
             freed, rejected, HOLD_CYCLES);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
hdl/bbia_pkg.sv
hdl/bbia_ram.sv
hdl/bitmap_block_inode_allocator_core.sv
tb/bitmap_block_inode_allocator_core_test.sv
